// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define NSEM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nsem assertion failed");

// expression must never be true outside reset
`define NSEM_NEVER(label, clk, rst_n, expr) \
    `NSEM_ASSERT(label, clk, rst_n, !(expr))

`endif

// ===== src/nsem_pkg.sv =====
// shared constants, codes and port structs of the named semaphore table
// no dependencies
`default_nettype none

package nsem_pkg;

    localparam int SLOTS      = 16;
    localparam int WAIT_DEPTH = 8;
    localparam int PROCS      = 64;

    localparam int SLOT_W  = 4;
    localparam int KEY_W   = 64;
    localparam int COUNT_W = 8;
    localparam int PID_W   = 6;
    localparam int WQ_W    = $clog2(WAIT_DEPTH);
    localparam int LEN_W   = $clog2(WAIT_DEPTH + 1);
    localparam int WADDR_W = SLOT_W + WQ_W;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        CMD_OPEN    = 2'd0,
        CMD_POST    = 2'd1,
        CMD_WAIT    = 2'd2,
        CMD_DESTROY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_BAD_SLOT   = 2'd1,
        STAT_TABLE_FULL = 2'd2,
        STAT_QUEUE_FULL = 2'd3
    } status_t;

    // write port of the key memory
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [KEY_W-1:0]  key;
    } key_wr_t;

    // write port of the waiter memory
    typedef struct packed {
        logic               en;
        logic [WADDR_W-1:0] addr;
        logic [PID_W-1:0]   pid;
    } wq_wr_t;

endpackage

`default_nettype wire

// ===== src/nsem_key_store.sv =====
// key memory of the semaphore slots with the single shared key comparator
// depends on nsem_pkg
`default_nettype none

module nsem_key_store import nsem_pkg::*; (
    input  wire logic              aclk,
    input  wire key_wr_t           wr,
    input  wire logic [SLOT_W-1:0] rd_addr,
    input  wire logic [KEY_W-1:0]  cmp_key,
    output logic                   key_match
);

    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [KEY_W-1:0] rd_key_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            key_mem[wr.addr] <= wr.key;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    // compares the key read in the previous cycle
    assign key_match = (rd_key_reg == cmp_key);

endmodule

`default_nettype wire

// ===== src/nsem_waiter_ram.sv =====
// waiter memory: one circular queue of process ids per slot
// depends on nsem_pkg
`default_nettype none

module nsem_waiter_ram import nsem_pkg::*; (
    input  wire logic               aclk,
    input  wire wq_wr_t             wr,
    input  wire logic [WADDR_W-1:0] rd_addr,
    output logic [PID_W-1:0]        rd_pid
);

    logic [PID_W-1:0] pid_mem [SLOTS*WAIT_DEPTH];
    logic [PID_W-1:0] rd_pid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            pid_mem[wr.addr] <= wr.pid;
        end
        rd_pid_reg <= pid_mem[rd_addr];
    end

    assign rd_pid = rd_pid_reg;

endmodule

`default_nettype wire

// ===== src/named_semaphore_table.sv =====
// top level of the named semaphore table: sequencer, slot state and result register
// depends on nsem_pkg, nsem_key_store, nsem_waiter_ram
//
//  channel  | group            | fields (lowest bit up)
//  ---------+------------------+------------------------------------------------------
//  input    | s_tvalid/tready  | tuser: cmd; tdata: slot_id, name_key, start_count,
//           |                  |   caller_pid, zero fill to 88 bits
//  result   | m_tvalid/tready  | tuser: status; tdata: slot_out, caller_blocked,
//           |                  |   woke_valid, woke_pid, zero fill to 16 bits
//
// open walks the key memory one slot per cycle through one 64-bit comparator:
//   the input is decoded, up to 16 slots are compared, then the result is loaded
// post with a waiter adds a waiter memory read before the result load; other commands load their result after decode
// one item at a time: s_tready is high only while the sequencer is idle
// a result waiting on m_tready holds the sequencer before its next load, not the input
// synchronous active-low reset clears slot flags and queue pointers, no clearing pass
`default_nettype none

module named_semaphore_table import nsem_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // slot_id, name_key, start_count, caller_pid
    input  wire logic [1:0]           s_tuser,  // cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // slot_out, caller_blocked, woke_valid, woke_pid
    output logic [1:0]                m_tuser   // status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_WAKE,
        S_RESP
    } state_t;

    state_t state_reg;

    // latched item
    cmd_t               cmd_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [COUNT_W-1:0] start_reg;
    logic [PID_W-1:0]   pid_reg;

    // slot state
    logic [SLOTS-1:0]   slot_used_reg;
    logic [COUNT_W-1:0] slot_count_reg [SLOTS];
    logic [WQ_W-1:0]    head_reg [SLOTS];
    logic [WQ_W-1:0]    tail_reg [SLOTS];
    logic [LEN_W-1:0]   len_reg [SLOTS];

    // scan
    logic [SLOT_W-1:0]  scan_idx_reg;
    logic [SLOT_W-1:0]  chk_idx_reg;
    logic               free_found_reg;
    logic [SLOT_W-1:0]  free_idx_reg;

    // pending result and output register
    status_t            res_status_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic               res_blocked_reg;
    logic               res_woke_reg;
    logic [PID_W-1:0]   res_pid_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    key_wr_t            key_wr;
    wq_wr_t             wq_wr;
    logic [WADDR_W-1:0] wq_rd_addr;
    logic [PID_W-1:0]   wq_rd_pid;
    logic               key_match;

    logic               chk_used;
    logic               scan_hit;
    logic               scan_last;
    logic               claim_ok;
    logic [SLOT_W-1:0]  claim_idx;
    logic               slot_ok;
    logic               pid_ok;
    logic [COUNT_W-1:0] cur_count;
    logic [WQ_W-1:0]    cur_head;
    logic [WQ_W-1:0]    cur_tail;
    logic [LEN_W-1:0]   cur_len;
    logic [WQ_W-1:0]    head_next;
    logic [WQ_W-1:0]    tail_next;
    logic               do_claim;
    logic               do_enqueue;
    logic               out_free;

    nsem_key_store u_key_store (
        .aclk      (aclk),
        .wr        (key_wr),
        .rd_addr   (scan_idx_reg),
        .cmp_key   (key_reg),
        .key_match (key_match)
    );

    nsem_waiter_ram u_waiter_ram (
        .aclk    (aclk),
        .wr      (wq_wr),
        .rd_addr (wq_rd_addr),
        .rd_pid  (wq_rd_pid)
    );

    always_comb begin
        chk_used  = slot_used_reg[chk_idx_reg];
        scan_hit  = chk_used && key_match;
        scan_last = (chk_idx_reg == SLOT_W'(SLOTS - 1));
        claim_ok  = free_found_reg || !chk_used;
        claim_idx = free_found_reg ? free_idx_reg : chk_idx_reg;
        do_claim  = (state_reg == S_SCAN) && !scan_hit && scan_last && claim_ok;

        slot_ok   = (int'(slot_reg) < SLOTS) && slot_used_reg[slot_reg];
        pid_ok    = (int'(pid_reg) < PROCS);
        cur_count = slot_count_reg[slot_reg];
        cur_head  = head_reg[slot_reg];
        cur_tail  = tail_reg[slot_reg];
        cur_len   = len_reg[slot_reg];
        head_next = (cur_head == WQ_W'(WAIT_DEPTH - 1)) ? '0 : cur_head + 1'b1;
        tail_next = (cur_tail == WQ_W'(WAIT_DEPTH - 1)) ? '0 : cur_tail + 1'b1;

        do_enqueue = (state_reg == S_EXEC) && (cmd_reg == CMD_WAIT) && slot_ok && pid_ok
                     && (cur_count == '0) && (cur_len < LEN_W'(WAIT_DEPTH));

        key_wr.en   = do_claim;
        key_wr.addr = claim_idx;
        key_wr.key  = key_reg;

        wq_wr.en    = do_enqueue;
        wq_wr.addr  = {slot_reg, cur_tail};
        wq_wr.pid   = pid_reg;
        wq_rd_addr  = {slot_reg, cur_head};

        out_free = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            slot_used_reg  <= '0;
            free_found_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                len_reg[i]  <= '0;
            end
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // scan pointers run ahead of the compare by the registered key read
            chk_idx_reg  <= scan_idx_reg;
            scan_idx_reg <= scan_idx_reg + 1'b1;

            case (state_reg)
                S_IDLE: begin
                    scan_idx_reg <= '0;
                    if (s_tvalid) begin
                        cmd_reg        <= cmd_t'(s_tuser);
                        slot_reg       <= s_tdata[3:0];
                        key_reg        <= s_tdata[67:4];
                        start_reg      <= s_tdata[75:68];
                        pid_reg        <= s_tdata[81:76];
                        free_found_reg <= 1'b0;
                        state_reg      <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    res_status_reg  <= STAT_OK;
                    res_slot_reg    <= '0;
                    res_blocked_reg <= 1'b0;
                    res_woke_reg    <= 1'b0;
                    res_pid_reg     <= '0;
                    state_reg       <= S_RESP;
                    if (cmd_reg == CMD_OPEN) begin
                        state_reg <= S_SCAN;
                    end else if (!slot_ok) begin
                        res_status_reg <= STAT_BAD_SLOT;
                    end else begin
                        case (cmd_reg)
                            CMD_POST: begin
                                if (cur_len != '0) begin
                                    head_reg[slot_reg] <= head_next;
                                    len_reg[slot_reg]  <= cur_len - 1'b1;
                                    state_reg          <= S_WAKE;
                                end else if (cur_count != '1) begin
                                    slot_count_reg[slot_reg] <= cur_count + 1'b1;
                                end
                            end
                            CMD_WAIT: begin
                                if (!pid_ok) begin
                                    res_status_reg <= STAT_BAD_SLOT;
                                end else if (cur_count != '0) begin
                                    slot_count_reg[slot_reg] <= cur_count - 1'b1;
                                end else if (!do_enqueue) begin
                                    res_status_reg <= STAT_QUEUE_FULL;
                                end else begin
                                    tail_reg[slot_reg] <= tail_next;
                                    len_reg[slot_reg]  <= cur_len + 1'b1;
                                    res_blocked_reg    <= 1'b1;
                                end
                            end
                            CMD_DESTROY: begin
                                slot_used_reg[slot_reg] <= 1'b0;
                            end
                            default: begin
                                res_status_reg <= STAT_OK;
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    if (!chk_used && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= chk_idx_reg;
                    end
                    if (scan_hit) begin
                        res_slot_reg <= chk_idx_reg;
                        state_reg    <= S_RESP;
                    end else if (scan_last) begin
                        state_reg <= S_RESP;
                        if (claim_ok) begin
                            slot_used_reg[claim_idx]  <= 1'b1;
                            slot_count_reg[claim_idx] <= start_reg;
                            head_reg[claim_idx]       <= '0;
                            tail_reg[claim_idx]       <= '0;
                            len_reg[claim_idx]        <= '0;
                            res_slot_reg              <= claim_idx;
                        end else begin
                            res_status_reg <= STAT_TABLE_FULL;
                        end
                    end
                end

                S_WAKE: begin
                    res_woke_reg <= 1'b1;
                    res_pid_reg  <= wq_rd_pid;
                    state_reg    <= S_RESP;
                end

                S_RESP: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {4'b0000, res_pid_reg, res_woke_reg,
                                         res_blocked_reg, res_slot_reg};
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== src/nsem_checker.sv =====
// port-level checks of the named semaphore table, bound to the top level
// depends on nsem_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module nsem_checker import nsem_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [1:0]           m_tuser
);

    // a stalled result holds
    `NSEM_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one item at a time: busy right after an input transfer
    `NSEM_ASSERT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)

    // a result never both blocks a caller and wakes a waiter
    `NSEM_NEVER(a_block_wake_excl, aclk, aresetn, m_tvalid && m_tdata[4] && m_tdata[5])

    // a blocked caller or a woken waiter only comes with an ok status
    `NSEM_ASSERT(a_flags_ok, aclk, aresetn, m_tvalid && (m_tdata[4] || m_tdata[5]) |-> m_tuser == STAT_OK)

endmodule

bind named_semaphore_table nsem_checker u_nsem_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_named_semaphore_table.sv =====
// self-checking testbench for named_semaphore_table: directed script, then random traffic
// depends on nsem_pkg and the named_semaphore_table rtl; predicts each result internally unless a script row gives it
`timescale 1ns / 100ps

module tb_named_semaphore_table;
    import nsem_pkg::*;

    localparam int RANDOM_ITEMS    = 1500;
    localparam int LIMIT_CYCLES    = 400_000;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 40;
    localparam int KEY_POOL        = 24;
    localparam int MAX_REPORTS     = 10;

    typedef enum int {
        MIX_FILL,
        MIX_CHURN,
        MIX_BLOCK,
        MIX_DRAIN
    } traffic_mix_t;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN,
        RX_CHOKED
    } rx_style_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [SLOT_W-1:0]    slot;
        logic [KEY_W-1:0]     key;
        logic [COUNT_W-1:0]   start;
        logic [PID_W-1:0]     pid;
    } sem_req_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic                 blocked;
        logic                 woke;
        logic [PID_W-1:0]     pid;
    } sem_result_t;

    typedef struct packed {
        sem_req_t             req;
        logic [3:0]           reps;
        logic                 typed;
        sem_result_t          want;
    } script_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    named_semaphore_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // shadow copy of the semaphore table
    logic                 tbl_used  [SLOTS];
    logic [KEY_W-1:0]     tbl_key   [SLOTS];
    logic [COUNT_W-1:0]   tbl_count [SLOTS];
    logic [PID_W-1:0]     pid_fifo  [SLOTS*WAIT_DEPTH];
    logic [WQ_W-1:0]      fifo_rd   [SLOTS];
    logic [WQ_W-1:0]      fifo_wr   [SLOTS];
    logic [LEN_W-1:0]     fifo_fill [SLOTS];

    sem_result_t          owed_results[$];
    script_row_t          script[$];
    logic [KEY_W-1:0]     key_pool [KEY_POOL];

    int                   bad_fields   = 0;
    int                   results_seen = 0;
    int                   cycle_count  = 0;
    int                   burst_left   = 0;
    bit                   sender_quiet = 1'b0;

    sem_result_t          mon_got;
    sem_result_t          mon_want;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic sem_result_t mk_res(status_t st, int slot, bit blocked, bit woke, int pid);
        sem_result_t r;
        r.status  = st;
        r.slot    = SLOT_W'(slot);
        r.blocked = blocked;
        r.woke    = woke;
        r.pid     = PID_W'(pid);
        return r;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++) begin
            tbl_used[i]  = 1'b0;
            fifo_rd[i]   = '0;
            fifo_wr[i]   = '0;
            fifo_fill[i] = '0;
        end
    endfunction

    // applies one command to the shadow table and returns the result it owes
    function automatic sem_result_t apply_request(sem_req_t rq);
        sem_result_t          r;
        int                   hit;
        int                   s;
        logic [WADDR_W-1:0]   a;
        r   = mk_res(STAT_OK, 0, 1'b0, 1'b0, 0);
        hit = -1;
        s   = int'(rq.slot);
        if (rq.cmd == CMD_OPEN) begin
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && tbl_used[i] && tbl_key[i] == rq.key)
                    hit = i;
            if (hit < 0) begin
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && !tbl_used[i])
                        hit = i;
                if (hit >= 0) begin
                    tbl_used[hit]  = 1'b1;
                    tbl_key[hit]   = rq.key;
                    tbl_count[hit] = rq.start;
                    fifo_rd[hit]   = '0;
                    fifo_wr[hit]   = '0;
                    fifo_fill[hit] = '0;
                end
            end
            if (hit >= 0)
                r.slot = SLOT_W'(hit);
            else
                r.status = STAT_TABLE_FULL;
        end else if (!tbl_used[s]) begin
            r.status = STAT_BAD_SLOT;
        end else begin
            case (rq.cmd)
                CMD_POST: begin
                    if (fifo_fill[s] != 0) begin
                        a          = {rq.slot, fifo_rd[s]};
                        r.woke     = 1'b1;
                        r.pid      = pid_fifo[a];
                        fifo_rd[s] = fifo_rd[s] + 1'b1;
                        fifo_fill[s] = fifo_fill[s] - 1'b1;
                    end else if (tbl_count[s] != 8'hff) begin
                        tbl_count[s] = tbl_count[s] + 1'b1;
                    end
                end
                CMD_WAIT: begin
                    if (int'(rq.pid) >= PROCS) begin
                        r.status = STAT_BAD_SLOT;
                    end else if (tbl_count[s] != 0) begin
                        tbl_count[s] = tbl_count[s] - 1'b1;
                    end else if (int'(fifo_fill[s]) >= WAIT_DEPTH) begin
                        r.status = STAT_QUEUE_FULL;
                    end else begin
                        a            = {rq.slot, fifo_wr[s]};
                        pid_fifo[a]  = rq.pid;
                        fifo_wr[s]   = fifo_wr[s] + 1'b1;
                        fifo_fill[s] = fifo_fill[s] + 1'b1;
                        r.blocked    = 1'b1;
                    end
                end
                default: begin
                    tbl_used[s] = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

    // random command, mostly aimed at live slots and a small pool of names
    function automatic sem_req_t next_request(traffic_mix_t mix);
        sem_req_t rq;
        int       roll;
        int       base;
        int       cand;
        bit       found;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  rq.cmd = roll < 40 ? CMD_OPEN : roll < 60 ? CMD_POST :
                                roll < 95 ? CMD_WAIT : CMD_DESTROY;
            MIX_CHURN: rq.cmd = roll < 25 ? CMD_OPEN : roll < 50 ? CMD_POST :
                                roll < 75 ? CMD_WAIT : CMD_DESTROY;
            MIX_BLOCK: rq.cmd = roll < 10 ? CMD_OPEN : roll < 25 ? CMD_POST :
                                roll < 95 ? CMD_WAIT : CMD_DESTROY;
            default:   rq.cmd = roll < 10 ? CMD_OPEN : roll < 70 ? CMD_POST :
                                roll < 90 ? CMD_WAIT : CMD_DESTROY;
        endcase
        rq.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
        if ($urandom_range(0, 99) < 85) begin
            base  = $urandom_range(0, SLOTS - 1);
            found = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                cand = (base + i) % SLOTS;
                if (!found && tbl_used[cand]) begin
                    rq.slot = SLOT_W'(cand);
                    found   = 1'b1;
                end
            end
        end
        if ($urandom_range(0, 99) < 65)
            rq.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else
            rq.key = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 35)
            rq.start = '0;
        else if (roll < 45)
            rq.start = 8'hff;
        else if (roll < 50)
            rq.start = 8'hfe;
        else
            rq.start = COUNT_W'($urandom_range(0, 255));
        rq.pid = PID_W'($urandom_range(0, PROCS - 1));
        return rq;
    endfunction

    task automatic add_row(cmd_t cmd, int slot, logic [KEY_W-1:0] key, int start, int pid,
                           int reps, bit typed, sem_result_t want);
        script_row_t row;
        row.req.cmd   = cmd;
        row.req.slot  = SLOT_W'(slot);
        row.req.key   = key;
        row.req.start = COUNT_W'(start);
        row.req.pid   = PID_W'(pid);
        row.reps      = 4'(reps);
        row.typed     = typed;
        row.want      = want;
        script.push_back(row);
    endtask

    // offers one command, with gaps between bursts, and returns once it is transferred
    task automatic send_request(sem_req_t rq);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = sender_quiet ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.cmd;
        s_tdata  <= {6'd0, rq.pid, rq.start, rq.key, rq.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            bad_fields++;
            if (bad_fields <= MAX_REPORTS)
                $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    // result side: each transfer is held against the oldest owed result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            mon_got.status  = status_t'(m_tuser);
            mon_got.slot    = m_tdata[3:0];
            mon_got.blocked = m_tdata[4];
            mon_got.woke    = m_tdata[5];
            mon_got.pid     = m_tdata[11:6];
            if (owed_results.size() == 0) begin
                bad_fields++;
                if (bad_fields <= MAX_REPORTS)
                    $display("%0t: unexpected result, status %0d tdata %0h",
                             $realtime, m_tuser, m_tdata);
            end else begin
                mon_want = owed_results.pop_front();
                check_field("status", 64'(mon_want.status), 64'(mon_got.status));
                check_field("slot_out", 64'(mon_want.slot), 64'(mon_got.slot));
                check_field("caller_blocked", 64'(mon_want.blocked), 64'(mon_got.blocked));
                check_field("woke_valid", 64'(mon_want.woke), 64'(mon_got.woke));
                check_field("woke_pid", 64'(mon_want.pid), 64'(mon_got.pid));
            end
        end
    end

    // receiver: changing stall styles, plus one long hold-off to back up the input
    initial begin
        rx_style_t style;
        int        style_left;
        int        phase;
        bit        held;
        style      = RX_OPEN;
        style_left = 0;
        phase      = 0;
        held       = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= HOLD_OFF_AT) begin
                held     = 1'b1;
                m_tready <= 1'b0;
                for (int i = 0; i < HOLD_OFF_CYCLES; i++)
                    @(negedge aclk);
            end else begin
                if (style_left == 0) begin
                    style      = rx_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(50, 300);
                end
                style_left--;
                phase++;
                case (style)
                    RX_OPEN:    m_tready <= 1'b1;
                    RX_RANDOM:  m_tready <= $urandom_range(0, 2) != 0;
                    RX_PATTERN: m_tready <= (phase % 7) < 4;
                    default:    m_tready <= $urandom_range(0, 5) == 0;
                endcase
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sem_req_t     rq;
        sem_result_t  predicted;
        script_row_t  row;
        traffic_mix_t mix;
        int           mix_left;
        clear_table();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};

        // unused slots, open by claim and by match, saturation, queue fill and wake order,
        // destroy with waiters, then a reclaimed slot whose queue starts empty
        add_row(CMD_POST,    0,  '0, 0, 0, 1, 1, mk_res(STAT_BAD_SLOT, 0, 0, 0, 0));
        add_row(CMD_WAIT,    15, '0, 0, 63, 1, 1, mk_res(STAT_BAD_SLOT, 0, 0, 0, 0));
        add_row(CMD_DESTROY, 3,  '0, 0, 0, 1, 1, mk_res(STAT_BAD_SLOT, 0, 0, 0, 0));
        add_row(CMD_OPEN,    0,  '0, 0, 0, 1, 1, mk_res(STAT_OK, 0, 0, 0, 0));
        add_row(CMD_OPEN,    15, '1, 255, 0, 1, 1, mk_res(STAT_OK, 1, 0, 0, 0));
        add_row(CMD_OPEN,    0,  '0, 9, 0, 1, 1, mk_res(STAT_OK, 0, 0, 0, 0));
        add_row(CMD_POST,    1,  '0, 0, 0, 1, 1, mk_res(STAT_OK, 0, 0, 0, 0));
        add_row(CMD_WAIT,    1,  '0, 0, 63, 1, 1, mk_res(STAT_OK, 0, 0, 0, 0));
        add_row(CMD_WAIT,    0,  '0, 0, 63, 1, 1, mk_res(STAT_OK, 0, 1, 0, 0));
        add_row(CMD_WAIT,    0,  '0, 0, 42, 7, 0, '0);
        add_row(CMD_WAIT,    0,  '1, 255, 1, 1, 1, mk_res(STAT_QUEUE_FULL, 0, 0, 0, 0));
        add_row(CMD_POST,    0,  '0, 0, 0, 1, 1, mk_res(STAT_OK, 0, 0, 1, 63));
        add_row(CMD_POST,    0,  '0, 0, 0, 1, 0, '0);
        add_row(CMD_DESTROY, 0,  '0, 0, 0, 1, 1, mk_res(STAT_OK, 0, 0, 0, 0));
        add_row(CMD_OPEN,    0,  64'h0123_4567_89ab_cdef, 0, 0, 1, 1,
                mk_res(STAT_OK, 0, 0, 0, 0));
        add_row(CMD_POST,    0,  '0, 0, 0, 1, 1, mk_res(STAT_OK, 0, 0, 0, 0));
        add_row(CMD_WAIT,    0,  '0, 0, 5, 1, 0, '0);
        add_row(CMD_DESTROY, 1,  '0, 0, 0, 1, 1, mk_res(STAT_OK, 0, 0, 0, 0));
        add_row(CMD_WAIT,    1,  '0, 0, 5, 1, 1, mk_res(STAT_BAD_SLOT, 0, 0, 0, 0));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            row = script[i];
            for (int n = 0; n < int'(row.reps); n++) begin
                send_request(row.req);
                predicted = apply_request(row.req);
                owed_results.push_back(row.typed ? row.want : predicted);
            end
        end

        mix      = MIX_FILL;
        mix_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mix_left == 0) begin
                mix      = traffic_mix_t'($urandom_range(0, 3));
                mix_left = $urandom_range(60, 200);
            end
            mix_left--;
            // a stretch with the sender never pausing
            sender_quiet = n >= 700 && n < 850;
            rq = next_request(mix);
            send_request(rq);
            owed_results.push_back(apply_request(rq));
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (owed_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (bad_fields == 0 && owed_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
